@@ rtl/core/oets_pkg.sv @@
// Shared types and constants for the odd-even transposition sorter.
// Used by oets_cell and odd_even_transposition_sorter_core; no dependencies.

package oets_pkg;

  // Default sizes of the sorter.
  localparam int DefaultMaxElements = 64;
  localparam int DefaultDataWidth   = 32;

  // Width of the stream value field.
  localparam int ValueW = 32;

  // Width of the held-element count; covers counts up to 127.
  localparam int CntW = 7;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  // Operation applied to every cell in the same cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_EVEN,
    CELL_ODD,
    CELL_SHIFT
  } cell_op_e;

  // Control broadcast from the sequencer to the row of cells.
  typedef struct packed {
    cell_op_e          op;
    logic [CntW-1:0]   count;
  } cell_ctrl_t;

endpackage

@@ rtl/core/odd_even_transposition_sorter_core.sv @@
// Top level of the odd-even transposition sorter: sequencer and row of cells.
// Depends on oets_pkg and oets_cell.
//
//   Channel   Dir  Fields (lowest bit first)
//   s_axis    in   tdata: value (32, signed); tlast: last
//   m_axis    out  tdata: value_res (32, signed); tlast: last_res; tuser: overflow
//
// A set of N held elements is loaded, sorted in N phases (all neighbor pairs
// compared at once in the cell row) and then emitted. Elements beyond
// MAX_ELEMENTS are dropped and flag every result of the set. Reset (rst_ni
// low, asynchronous) empties the set. Input is taken only while loading;
// results wait in the cell row as long as m_axis_tready_i is low.

module odd_even_transposition_sorter_core #(
  parameter int MAX_ELEMENTS = oets_pkg::DefaultMaxElements,
  parameter int DATA_WIDTH   = oets_pkg::DefaultDataWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic signed [oets_pkg::ValueW-1:0]   s_axis_tdata_i,  // value
  input  logic                                 s_axis_tlast_i,  // last
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic signed [oets_pkg::ValueW-1:0]   m_axis_tdata_o,  // value_res
  output logic                                 m_axis_tlast_o,  // last_res
  output logic                                 m_axis_tuser_o   // overflow
);
  import oets_pkg::*;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [CntW-1:0]              step_q, step_d;
  logic                         dropped_q, dropped_d;
  cell_ctrl_t                   ctrl;
  logic                         in_fire;
  logic                         out_fire;
  logic                         full;
  logic                         step_end;
  logic signed [DATA_WIDTH-1:0] in_value;
  logic signed [DATA_WIDTH-1:0] cell_value [MAX_ELEMENTS];

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign full     = (count_q == CntW'(MAX_ELEMENTS));
  assign step_end = (step_q == count_q - CntW'(1));

  // Element width conversion: sign-extend or wrap to DATA_WIDTH.
  assign in_value = DATA_WIDTH'(s_axis_tdata_i);

  // Sequencer: next state, counters and the broadcast cell operation.
  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    step_d          = step_q;
    dropped_d       = dropped_q;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    ctrl.op         = CELL_HOLD;
    ctrl.count      = count_q;
    unique case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (in_fire) begin
          ctrl.op = CELL_LOAD;
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (s_axis_tlast_i) begin
            state_d = ST_SORT;
            step_d  = '0;
          end
        end
      end
      ST_SORT: begin
        ctrl.op = step_q[0] ? CELL_ODD : CELL_EVEN;
        if (step_end) begin
          state_d = ST_EMIT;
          step_d  = '0;
        end else begin
          step_d = step_q + CntW'(1);
        end
      end
      ST_EMIT: begin
        m_axis_tvalid_o = 1'b1;
        if (out_fire) begin
          ctrl.op = CELL_SHIFT;
          step_d  = step_q + CntW'(1);
          if (step_end) begin
            state_d   = ST_LOAD;
            count_d   = '0;
            dropped_d = 1'b0;
            step_d    = '0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      step_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      step_q    <= step_d;
      dropped_q <= dropped_d;
    end
  end

  // Row of cells; each cell sees its two neighbors.
  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_value;
    logic signed [DATA_WIDTH-1:0] right_value;

    if (g == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_inner_left
      assign left_value = cell_value[g-1];
    end

    if (g == MAX_ELEMENTS - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner_right
      assign right_value = cell_value[g+1];
    end

    oets_cell #(
      .IDX        (g),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .load_value_i  (in_value),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (cell_value[g])
    );
  end

  // Results leave from the head cell of the row.
  assign m_axis_tdata_o = ValueW'(cell_value[0]);
  assign m_axis_tlast_o = step_end;
  assign m_axis_tuser_o = dropped_q;

  // Loading and emitting never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output open at the same time");

  // The held count never exceeds the row length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ELEMENTS))
    else $error("held count beyond row length");

  // Sorting and emitting always work on a non-empty set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT || state_q == ST_EMIT) |-> (count_q != '0))
    else $error("sort or emit with empty set");

  // After the final result is taken the set is empty and loading resumes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast_o) |=> (count_q == '0 && state_q == ST_LOAD
                                      && !dropped_q))
    else $error("set not cleared after final result");

endmodule

@@ rtl/core/oets_cell.sv @@
// One cell of the sorting row: holds one element and compare-exchanges it
// with a neighbor. Depends on oets_pkg.

module oets_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  oets_pkg::cell_ctrl_t         ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] load_value_i,
  input  logic signed [DATA_WIDTH-1:0] left_value_i,
  input  logic signed [DATA_WIDTH-1:0] right_value_i,
  output logic signed [DATA_WIDTH-1:0] value_o
);
  import oets_pkg::*;

  localparam bit IsOdd    = (IDX % 2) == 1;
  localparam bit HasLeft  = IDX > 0;

  logic signed [DATA_WIDTH-1:0] value_q, value_d;
  logic                         pair_left;   // this cell is the left of a pair
  logic                         pair_right;  // this cell is the right of a pair
  logic                         left_ok;
  logic                         right_ok;

  // A pair takes part only when both of its cells hold elements.
  assign left_ok  = (CntW'(IDX + 1) < ctrl_i.count);
  assign right_ok = HasLeft && (CntW'(IDX) < ctrl_i.count);

  // Next value of the cell for the broadcast operation.
  always_comb begin
    value_d    = value_q;
    pair_left  = 1'b0;
    pair_right = 1'b0;
    unique case (ctrl_i.op)
      CELL_LOAD: begin
        if (ctrl_i.count == CntW'(IDX)) begin
          value_d = load_value_i;
        end
      end
      CELL_EVEN, CELL_ODD: begin
        pair_left  = (ctrl_i.op == CELL_ODD) == IsOdd;
        pair_right = !pair_left;
        if (pair_left && left_ok && (right_value_i < value_q)) begin
          value_d = right_value_i;
        end else if (pair_right && right_ok && (left_value_i > value_q)) begin
          value_d = left_value_i;
        end
      end
      CELL_SHIFT: begin
        value_d = right_value_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  // Element register; payload only, no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
